// ===== rtl/pltbl_pkg.sv =====
// ----------------------------------------------------------------------------
// pltbl_pkg
// Shared constants, codes, state type and controller/datapath structs of the
// piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package pltbl_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int KEY_WIDTH       = 32;
    localparam int OP_WIDTH        = 2;
    localparam int STATUS_WIDTH    = 2;
    localparam int GAP_WIDTH       = 16;
    localparam int FRAC_WIDTH      = 16;
    localparam int NUM_FIELDS      = 3;

    localparam logic [GAP_WIDTH-1:0] GAP_RESET = GAP_WIDTH'(1);

    localparam logic [OP_WIDTH-1:0] OP_CLEAR  = OP_WIDTH'(0);
    localparam logic [OP_WIDTH-1:0] OP_APPEND = OP_WIDTH'(1);
    localparam logic [OP_WIDTH-1:0] OP_QUERY  = OP_WIDTH'(2);

    localparam logic [STATUS_WIDTH-1:0] ST_OK    = STATUS_WIDTH'(0);
    localparam logic [STATUS_WIDTH-1:0] ST_SHORT = STATUS_WIDTH'(1);
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = STATUS_WIDTH'(2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CMP_FIRST,
        S_CMP_LAST,
        S_WALK,
        S_GAP,
        S_TAKE_ROW,
        S_DIV,
        S_LO,
        S_HI,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        KA_ZERO,
        KA_LAST,
        KA_IDX,
        KA_NEXT
    } t_key_addr;

    typedef enum logic [1:0] {
        VA_ZERO,
        VA_LAST,
        VA_IDX,
        VA_PREV
    } t_val_addr;

    typedef enum logic {
        RS_ZERO,
        RS_ROW
    } t_res_src;

    typedef struct packed {
        logic                    latch;
        logic                    clear;
        logic                    append;
        t_key_addr               key_addr;
        t_val_addr               val_addr;
        logic                    idx_init;
        logic                    idx_step;
        logic                    gap_cap;
        logic                    div_init;
        logic                    div_step;
        logic                    lo_cap;
        logic                    hi_cap;
        logic                    diff;
        logic                    mul;
        logic                    acc;
        logic                    res_set;
        t_res_src                res_src;
        logic [STATUS_WIDTH-1:0] res_status;
        logic                    out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_WIDTH-1:0] op;
        logic                short;
        logic                full;
        logic                key_le;
        logic                key_ge;
        logic                walk_more;
        logic                degen;
        logic                div_last;
        logic                mul_last;
    } t_stat;

endpackage

// ===== rtl/pltbl_ifs.sv =====
// ----------------------------------------------------------------------------
// pltbl channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pltbl_in_if
    import pltbl_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [OP_WIDTH-1:0]           operation;
    logic signed [KEY_WIDTH-1:0]   key;
    logic signed [VALUE_WIDTH-1:0] axial_in;
    logic signed [VALUE_WIDTH-1:0] moment_in;
    logic signed [VALUE_WIDTH-1:0] tangent_in;

    modport source (
        output valid, operation, key, axial_in, moment_in, tangent_in,
        input  ready
    );
    modport sink (
        input  valid, operation, key, axial_in, moment_in, tangent_in,
        output ready
    );
endinterface

interface pltbl_out_if
    import pltbl_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic [STATUS_WIDTH-1:0]       status;
    logic signed [VALUE_WIDTH-1:0] axial_out;
    logic signed [VALUE_WIDTH-1:0] moment_out;
    logic signed [VALUE_WIDTH-1:0] tangent_out;

    modport source (
        output valid, status, axial_out, moment_out, tangent_out,
        input  ready
    );
    modport sink (
        input  valid, status, axial_out, moment_out, tangent_out,
        output ready
    );
endinterface

// ===== rtl/pltbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// pltbl_ctrl
// Sequencer of the interpolator: decodes items, walks the key table, runs the
// divider and the per-field interpolation, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module pltbl_ctrl
    import pltbl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_QUERY && !i_stat.short) begin
                    n_state = S_CMP_FIRST;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP_FIRST: n_state = i_stat.key_le ? S_TAKE_ROW : S_CMP_LAST;
            S_CMP_LAST:  n_state = i_stat.key_ge ? S_TAKE_ROW : S_WALK;
            S_WALK:      n_state = i_stat.walk_more ? S_WALK : S_GAP;
            S_GAP:       n_state = i_stat.degen ? S_TAKE_ROW : S_DIV;
            S_TAKE_ROW:  n_state = S_DONE;
            S_DIV:       n_state = i_stat.div_last ? S_LO : S_DIV;
            S_LO:        n_state = S_HI;
            S_HI:        n_state = S_DIFF;
            S_DIFF:      n_state = S_MUL;
            S_MUL:       n_state = S_ACC;
            S_ACC:       n_state = i_stat.mul_last ? S_DONE : S_DIFF;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = w_accept;
            end
            S_DECODE: begin
                priority if (i_stat.op == OP_CLEAR) begin
                    o_cmd.clear      = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                end else if (i_stat.op == OP_APPEND) begin
                    o_cmd.append     = !i_stat.full;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = i_stat.full ? ST_FULL : ST_OK;
                end else if (i_stat.op == OP_QUERY) begin
                    if (i_stat.short) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_status = ST_SHORT;
                    end else begin
                        o_cmd.key_addr = KA_ZERO;
                    end
                end else begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                end
            end
            S_CMP_FIRST: begin
                o_cmd.idx_init = 1'b1;
                o_cmd.key_addr = KA_LAST;
                o_cmd.val_addr = i_stat.key_le ? VA_ZERO : VA_LAST;
            end
            S_CMP_LAST: begin
                o_cmd.key_addr = KA_IDX;
                o_cmd.val_addr = VA_LAST;
            end
            S_WALK: begin
                if (i_stat.walk_more) begin
                    o_cmd.idx_step = 1'b1;
                    o_cmd.key_addr = KA_NEXT;
                end else begin
                    o_cmd.gap_cap = 1'b1;
                end
            end
            S_GAP: begin
                if (i_stat.degen) begin
                    o_cmd.val_addr = VA_IDX;
                end else begin
                    o_cmd.div_init   = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.val_addr   = VA_PREV;
                end
            end
            S_TAKE_ROW: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_src    = RS_ROW;
                o_cmd.res_status = ST_OK;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.val_addr = VA_PREV;
            end
            S_LO: begin
                o_cmd.lo_cap   = 1'b1;
                o_cmd.val_addr = VA_IDX;
            end
            S_HI: begin
                o_cmd.hi_cap = 1'b1;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/pltbl_dpath.sv =====
// ----------------------------------------------------------------------------
// pltbl_dpath
// Breakpoint memories, walk index, serial fraction divider, shared
// interpolation multiplier, result and output registers.
// ----------------------------------------------------------------------------
module pltbl_dpath
    import pltbl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [GAP_WIDTH-1:0]          i_cfg_wr_data,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic [OP_WIDTH-1:0]           i_operation,
    input  logic signed [KEY_WIDTH-1:0]   i_key,
    input  logic signed [VALUE_WIDTH-1:0] i_axial_in,
    input  logic signed [VALUE_WIDTH-1:0] i_moment_in,
    input  logic signed [VALUE_WIDTH-1:0] i_tangent_in,
    output logic [STATUS_WIDTH-1:0]       o_status,
    output logic signed [VALUE_WIDTH-1:0] o_axial_out,
    output logic signed [VALUE_WIDTH-1:0] o_moment_out,
    output logic signed [VALUE_WIDTH-1:0] o_tangent_out
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int DW   = KEY_WIDTH + 1;
    localparam int CNTW = $clog2(FRAC_WIDTH);
    localparam int MW   = $clog2(NUM_FIELDS);
    localparam int PW   = VALUE_WIDTH + FRAC_WIDTH + 2;

    typedef logic [NUM_FIELDS-1:0][VALUE_WIDTH-1:0] t_row;

    logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
    t_row                 val_mem [TABLE_DEPTH];

    logic [GAP_WIDTH-1:0]          r_gap;
    logic [CW-1:0]                 r_count;
    logic [OP_WIDTH-1:0]           r_op;
    logic signed [KEY_WIDTH-1:0]   r_key;
    t_row                          r_row_in;
    logic [IW-1:0]                 r_idx;
    logic signed [KEY_WIDTH-1:0]   r_lo_key;
    logic signed [KEY_WIDTH-1:0]   r_key_rd;
    t_row                          r_val_rd;
    logic [DW-1:0]                 r_num;
    logic signed [DW-1:0]          r_den;
    logic                          r_eq;
    logic [DW-1:0]                 r_rem;
    logic [FRAC_WIDTH-1:0]         r_quo;
    logic [CNTW-1:0]               r_dcnt;
    t_row                          r_lo_row;
    t_row                          r_hi_row;
    logic [MW-1:0]                 r_mcnt;
    logic signed [VALUE_WIDTH:0]   r_diff;
    logic signed [PW-1:0]          r_prod;
    logic [STATUS_WIDTH-1:0]       r_res_status;
    t_row                          r_res;
    logic [STATUS_WIDTH-1:0]       r_out_status;
    t_row                          r_out_row;

    logic [IW-1:0]              w_last;
    logic [IW-1:0]              w_key_addr;
    logic [IW-1:0]              w_val_addr;
    logic [DW:0]                w_shift;
    logic [DW:0]                w_trial;
    logic signed [PW-1:0]       w_step;
    logic [VALUE_WIDTH-1:0]     w_lerp;
    logic signed [DW-1:0]       w_gap_ext;

    assign w_last    = IW'(r_count - CW'(1));
    assign w_gap_ext = $signed({(DW - GAP_WIDTH)'(0), r_gap});

    always_comb begin
        unique case (i_cmd.key_addr)
            KA_ZERO: w_key_addr = '0;
            KA_LAST: w_key_addr = w_last;
            KA_IDX:  w_key_addr = r_idx;
            KA_NEXT: w_key_addr = r_idx + IW'(1);
            default: w_key_addr = r_idx;
        endcase
    end

    always_comb begin
        unique case (i_cmd.val_addr)
            VA_ZERO: w_val_addr = '0;
            VA_LAST: w_val_addr = w_last;
            VA_IDX:  w_val_addr = r_idx;
            VA_PREV: w_val_addr = r_idx - IW'(1);
            default: w_val_addr = r_idx;
        endcase
    end

    // restoring divide step, one quotient bit a cycle
    assign w_shift = {r_rem, 1'b0};
    assign w_trial = w_shift - {1'b0, r_den};

    assign w_step = r_prod >>> FRAC_WIDTH;
    assign w_lerp = r_lo_row[r_mcnt] + w_step[VALUE_WIDTH-1:0];

    // breakpoint memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            key_mem[r_count[IW-1:0]] <= r_key;
            val_mem[r_count[IW-1:0]] <= r_row_in;
        end
        r_key_rd <= key_mem[w_key_addr];
        r_val_rd <= val_mem[w_val_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_operation;
            r_key    <= i_key;
            r_row_in <= {i_tangent_in, i_moment_in, i_axial_in};
        end
        if (i_cmd.idx_init) begin
            r_idx    <= IW'(1);
            r_lo_key <= r_key_rd;
        end else if (i_cmd.idx_step) begin
            r_idx    <= r_idx + IW'(1);
            r_lo_key <= r_key_rd;
        end
        if (i_cmd.gap_cap) begin
            r_den <= {r_key_rd[KEY_WIDTH-1], r_key_rd} - {r_lo_key[KEY_WIDTH-1], r_lo_key};
            r_num <= {r_key[KEY_WIDTH-1], r_key} - {r_lo_key[KEY_WIDTH-1], r_lo_key};
            r_eq  <= (r_key == r_key_rd);
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_num;
            r_quo  <= '0;
            r_dcnt <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + CNTW'(1);
            if (!w_trial[DW]) begin
                r_rem <= w_trial[DW-1:0];
                r_quo <= {r_quo[FRAC_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_quo <= {r_quo[FRAC_WIDTH-2:0], 1'b0};
            end
        end else if (i_cmd.acc) begin
            r_mcnt <= r_mcnt + MW'(1);
        end
        if (i_cmd.lo_cap) begin
            r_lo_row <= r_val_rd;
        end
        if (i_cmd.hi_cap) begin
            r_hi_row <= r_val_rd;
        end
        if (i_cmd.diff) begin
            r_diff <= $signed({r_hi_row[r_mcnt][VALUE_WIDTH-1], r_hi_row[r_mcnt]})
                    - $signed({r_lo_row[r_mcnt][VALUE_WIDTH-1], r_lo_row[r_mcnt]});
        end
        if (i_cmd.mul) begin
            r_prod <= r_diff * $signed({1'b0, r_quo});
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res        <= (i_cmd.res_src == RS_ROW) ? r_val_rd : '0;
        end else if (i_cmd.acc) begin
            r_res[r_mcnt] <= w_lerp;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_row    <= r_res;
        end
    end

    always_comb begin
        o_stat.op        = r_op;
        o_stat.short     = (r_count < CW'(2));
        o_stat.full      = (r_count == CW'(TABLE_DEPTH));
        o_stat.key_le    = (r_key <= r_key_rd);
        o_stat.key_ge    = (r_key >= r_key_rd);
        o_stat.walk_more = (r_idx != w_last) && (r_key > r_key_rd);
        o_stat.degen     = r_eq || r_den[DW-1] || (r_den == '0) || (r_den < w_gap_ext);
        o_stat.div_last  = (r_dcnt == CNTW'(FRAC_WIDTH - 1));
        o_stat.mul_last  = (r_mcnt == MW'(NUM_FIELDS - 1));
    end

    assign o_status      = r_out_status;
    assign o_axial_out   = r_out_row[0];
    assign o_moment_out  = r_out_row[1];
    assign o_tangent_out = r_out_row[2];

endmodule

// ===== rtl/piecewise_linear_table_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_unit
// Piecewise-linear lookup over a table of Q16.16 breakpoints.
// ----------------------------------------------------------------------------
// Takes one item at a time. Clear, append, the unused code and a query on a
// short table go from decode straight to done. A query at or below the first
// breakpoint, or at or above the last, returns that breakpoint's row. A query
// that lands inside the table walks the key memory one breakpoint per cycle;
// a degenerate interval then returns the upper breakpoint's row, otherwise a
// serial 16-bit fraction divider and one shared multiplier over the three
// values blend the two rows.
// The result sits in an output register, so the next input transfer is taken
// while a result still waits on the output channel. min_key_gap resets to 1.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_unit
    import pltbl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [GAP_WIDTH-1:0] i_cfg_wr_data,
    pltbl_in_if.sink             i_in,
    pltbl_out_if.source          o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pltbl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pltbl_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_in.operation),
        .i_key         (i_in.key),
        .i_axial_in    (i_in.axial_in),
        .i_moment_in   (i_in.moment_in),
        .i_tangent_in  (i_in.tangent_in),
        .o_status      (o_out.status),
        .o_axial_out   (o_out.axial_out),
        .o_moment_out  (o_out.moment_out),
        .o_tangent_out (o_out.tangent_out)
    );

endmodule

// ===== rtl/pltbl_chk.sv =====
// ----------------------------------------------------------------------------
// pltbl_chk
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module pltbl_chk
    import pltbl_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [STATUS_WIDTH-1:0] i_out_status,
    input logic [VALUE_WIDTH-1:0]  i_out_axial,
    input logic [VALUE_WIDTH-1:0]  i_out_moment,
    input logic [VALUE_WIDTH-1:0]  i_out_tangent
);

    // one item at a time: busy right after an input transfer
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready
    ) else $error("input ready after transfer");

    // error results carry zero values
    a_zero_on_error: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |->
            i_out_axial == '0 && i_out_moment == '0 && i_out_tangent == '0
    ) else $error("nonzero values with error status");

    a_reset_empty: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !i_out_valid
    ) else $error("result valid after reset");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
    ) else $error("result dropped while stalled");

endmodule

bind piecewise_linear_table_interpolator_unit pltbl_chk #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pltbl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_axial   (o_out.axial_out),
    .i_out_moment  (o_out.moment_out),
    .i_out_tangent (o_out.tangent_out)
);

// ===== tb/sv/piecewise_linear_table_interpolator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_unit_test
// Drives clear, append, query and unused-code transfers into the table
// interpolator and compares every result with a cycle-free model of the
// breakpoint table, under random idling on both channels, a long output
// hold-off and several min_key_gap settings.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_unit_test;
    import pltbl_pkg::*;

    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int VW           = DEF_VALUE_WIDTH;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 31;

    localparam logic [OP_WIDTH-1:0] OP_UNUSED = OP_WIDTH'(3);

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [VW-1:0]           axial;
        logic [VW-1:0]           moment;
        logic [VW-1:0]           tangent;
    } t_lookup_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [GAP_WIDTH-1:0] cfg_wr_data;

    pltbl_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
    pltbl_out_if #(.VALUE_WIDTH(VW)) out_ch ();

    piecewise_linear_table_interpolator_unit #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // model of the breakpoint table
    longint tbl_key     [DEPTH];
    longint tbl_axial   [DEPTH];
    longint tbl_moment  [DEPTH];
    longint tbl_tangent [DEPTH];
    int     entries = 0;
    longint min_gap = GAP_RESET;

    t_lookup_answer awaited_answers[$];
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  cycle_count    = 0;
    bit  src_idle_on    = 1'b1;
    bit  sink_idle_on   = 1'b1;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  hold_left      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("piecewise_linear_table_interpolator_unit: mismatch");
        $finish;
    end

    function automatic longint lerp_q16(input longint lo, input longint hi,
                                        input longint frac);
        longint prod;
        prod = frac * (hi - lo);
        return lo + (prod >>> 16);
    endfunction

    function automatic t_lookup_answer predict_lookup(
        input logic [OP_WIDTH-1:0]    op,
        input logic signed [KEY_WIDTH-1:0] key_in,
        input logic signed [VW-1:0]   ax,
        input logic signed [VW-1:0]   mo,
        input logic signed [VW-1:0]   ta
    );
        t_lookup_answer ans;
        longint k, denom, frac, va, vm, vt;
        int last, row;
        bit blend;
        ans   = '0;
        k     = key_in;
        row   = -1;
        blend = 1'b0;
        frac  = 0;
        case (op)
            OP_CLEAR: entries = 0;
            OP_APPEND: begin
                if (entries >= DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    tbl_key[entries]     = k;
                    tbl_axial[entries]   = ax;
                    tbl_moment[entries]  = mo;
                    tbl_tangent[entries] = ta;
                    entries++;
                end
            end
            OP_QUERY: begin
                last = entries - 1;
                if (entries < 2) begin
                    ans.status = ST_SHORT;
                end else if (k <= tbl_key[0]) begin
                    row = 0;
                end else if (k >= tbl_key[last]) begin
                    row = last;
                end else begin
                    row = 1;
                    while (row < last && k > tbl_key[row])
                        row++;
                    denom = tbl_key[row] - tbl_key[row-1];
                    // degenerate interval falls back to the upper entry
                    if (k != tbl_key[row] && denom > 0 && denom >= min_gap) begin
                        blend = 1'b1;
                        frac  = ((k - tbl_key[row-1]) <<< FRAC_WIDTH) / denom;
                        if (frac > 65535)
                            frac = 65535;
                    end
                end
            end
            default: ;
        endcase
        if (row >= 0) begin
            if (blend) begin
                va = lerp_q16(tbl_axial[row-1], tbl_axial[row], frac);
                vm = lerp_q16(tbl_moment[row-1], tbl_moment[row], frac);
                vt = lerp_q16(tbl_tangent[row-1], tbl_tangent[row], frac);
            end else begin
                va = tbl_axial[row];
                vm = tbl_moment[row];
                vt = tbl_tangent[row];
            end
            ans.axial   = VW'(va);
            ans.moment  = VW'(vm);
            ans.tangent = VW'(vt);
        end
        return ans;
    endfunction

    // output side: random idling plus a counted hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !sink_idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic note_mismatch(input string what, input t_lookup_answer want,
                                 input t_lookup_answer got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected status %0d axial %h moment %h tangent %h,", what,
                     want.status, want.axial, want.moment, want.tangent,
                     " got status %0d axial %h moment %h tangent %h",
                     got.status, got.axial, got.moment, got.tangent);
    endtask

    always @(posedge i_clk) begin
        t_lookup_answer want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.status, out_ch.axial_out, out_ch.moment_out, out_ch.tangent_out};
            if (awaited_answers.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = awaited_answers.pop_front();
                if (got !== want)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    task automatic send_item(input logic [OP_WIDTH-1:0] op, input logic [KEY_WIDTH-1:0] key,
                             input logic [VW-1:0] ax, input logic [VW-1:0] mo,
                             input logic [VW-1:0] ta);
        t_lookup_answer ans;
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.key        <= key;
        in_ch.axial_in   <= ax;
        in_ch.moment_in  <= mo;
        in_ch.tangent_in <= ta;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        ans = predict_lookup(op, key, ax, mo, ta);
        awaited_answers = {awaited_answers, ans};
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_gap(input logic [GAP_WIDTH-1:0] gap);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gap;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        min_gap = gap;
    endtask

    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VW-1){1'b0}}};
            1:       return {1'b0, {(VW-1){1'b1}}};
            2:       return '0;
            default: return VW'($urandom);
        endcase
    endfunction

    function automatic logic [GAP_WIDTH-1:0] random_gap();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return GAP_RESET;
            3:       return GAP_WIDTH'($urandom_range(0, 400));
            default: return GAP_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    // mostly inside the table span, sometimes on a breakpoint or anywhere
    function automatic logic [KEY_WIDTH-1:0] pick_query_key();
        longint lo, hi, span, t;
        if (entries == 0)
            return $urandom;
        lo = tbl_key[0];
        hi = tbl_key[entries-1];
        case ($urandom_range(0, 9))
            0:    return $urandom;
            1, 2: return KEY_WIDTH'(tbl_key[$urandom_range(0, entries-1)]);
            default: begin
                if (hi < lo) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                lo = lo - 16;
                hi = hi + 16;
                if (lo < -64'sd2147483648)
                    lo = -64'sd2147483648;
                if (hi > 64'sd2147483647)
                    hi = 64'sd2147483647;
                span = hi - lo + 1;
                return KEY_WIDTH'(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task automatic load_sorted_table(input int count);
        longint cur;
        int step_max;
        case ($urandom_range(0, 2))
            0:       step_max = 400;
            1:       step_max = 1 << 20;
            default: step_max = 1 << 26;
        endcase
        cur = longint'(int'($urandom));
        if ($urandom_range(0, 1))
            cur = cur >>> 1;
        repeat (count) begin
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            send_item(OP_APPEND, KEY_WIDTH'(cur), random_value(), random_value(),
                      random_value());
            cur = cur + $urandom_range(0, step_max);
        end
    endtask

    task automatic test_empty_table();
        send_item(OP_QUERY, '0, '1, '1, '1);
        send_item(OP_UNUSED, '1, '1, '1, '1);
        send_item(OP_APPEND, '0, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        send_item(OP_QUERY, '0, '0, '0, '0);
        send_item(OP_CLEAR, '1, '1, '1, '1);
    endtask

    task automatic test_table_edges();
        send_item(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
        send_item(OP_APPEND, 32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_APPEND, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678, 32'h8000_0000);
        send_item(OP_APPEND, 32'h0000_0064, 32'hffff_ffff, 32'hedcb_a987, 32'h7fff_ffff);
        send_item(OP_APPEND, 32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001);
        send_item(OP_QUERY, 32'h8000_0000, '0, '0, '0);
        send_item(OP_QUERY, 32'h7fff_ffff, '0, '0, '0);
        send_item(OP_QUERY, 32'hffff_0000, '0, '0, '0);
        send_item(OP_QUERY, 32'hffff_8000, '0, '0, '0);
        send_item(OP_QUERY, 32'hc000_0000, '0, '0, '0);
        send_item(OP_QUERY, 32'h0000_0032, '0, '0, '0);
        // narrow interval turns degenerate with the widest gap setting
        write_min_gap('1);
        send_item(OP_QUERY, 32'h0000_0032, '0, '0, '0);
        write_min_gap('0);
        send_item(OP_QUERY, 32'h0000_0032, '0, '0, '0);
        send_item(OP_QUERY, 32'h0000_0064, '0, '0, '0);
        send_item(OP_QUERY, 32'h7fff_fffe, '0, '0, '0);
    endtask

    task automatic test_table_full();
        send_item(OP_CLEAR, '0, '0, '0, '0);
        load_sorted_table(DEPTH);
        send_item(OP_APPEND, '1, random_value(), random_value(), random_value());
        repeat (4) send_item(OP_QUERY, pick_query_key(), $urandom, $urandom, $urandom);
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        send_item(OP_CLEAR, '0, '0, '0, '0);
        hold_requests++;
        load_sorted_table(4);
        repeat (10) send_item(OP_QUERY, pick_query_key(), '0, '0, '0);
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random(input int target);
        int start, done, next_cfg, size_pick, n;
        start    = items_sent;
        next_cfg = 0;
        while (items_sent - start < target) begin
            done = items_sent - start;
            // one long stretch with no idling on either side
            src_idle_on  = !(done >= 600 && done < 900);
            sink_idle_on = src_idle_on;
            if (done >= next_cfg) begin
                write_min_gap(random_gap());
                next_cfg = next_cfg + 300;
            end
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 99) < 85)
                    send_item(OP_CLEAR, $urandom, random_value(), random_value(),
                              random_value());
                size_pick = $urandom_range(0, 99);
                if (size_pick < 70)
                    n = $urandom_range(2, 6);
                else if (size_pick < 90)
                    n = $urandom_range(7, 20);
                else if (size_pick < 98)
                    n = $urandom_range(21, DEPTH);
                else
                    n = $urandom_range(0, 1);
                load_sorted_table(n);
                repeat ($urandom_range(1, 8))
                    send_item(OP_QUERY, pick_query_key(), $urandom, $urandom, $urandom);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(OP_WIDTH'($urandom_range(0, 3)), $urandom, random_value(),
                              random_value(), random_value());
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_CLEAR;
        in_ch.key        = '0;
        in_ch.axial_in   = '0;
        in_ch.moment_in  = '0;
        in_ch.tangent_in = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_table_edges();
        test_table_full();
        test_backpressure();
        test_random(1800);
        wait_drained();
        if (mismatch_count == 0 && awaited_answers.size() == 0)
            $display("piecewise_linear_table_interpolator_unit: match");
        else
            $display("piecewise_linear_table_interpolator_unit: mismatch");
        $finish;
    end

endmodule
